FILE: design/scet_pkg.sv
// Package for the split cosine edge taper unit: widths, fixed-point
// constants, register indexes and the sine series reciprocals.
// No dependencies.
package scet_pkg;

    // Configuration register width and indexes
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_FRACTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_FRACTION   = 2'd2;

    // Reset values of the registers
    localparam logic [CFG_W-1:0] RST_SAMPLE_COUNT = 17'd1024;
    localparam logic [CFG_W-1:0] RST_FRACTION     = 17'd32768;
    localparam logic [CFG_W-1:0] FRACTION_ONE     = 17'd65536;

    // Default parameter values
    localparam int DEF_MAX_SAMPLES = 65536;
    localparam int DEF_SAMPLE_BITS = 24;

    // Fixed point
    localparam int GAIN_W = 20;
    localparam int PHASE_W = 21;
    localparam int PHASE_FRAC = 20;
    localparam int Q30_W = 31;
    localparam int FACTOR_W = 17;
    localparam logic [Q30_W-1:0]    Q30_ONE     = 31'd1073741824;
    localparam logic [31:0]         PI_HALF_Q30 = 32'd1686629713;
    localparam logic [PHASE_W-1:0]  PHASE_ONE   = 21'd1048576;
    localparam logic [PHASE_W-1:0]  PHASE_HALF  = 21'd524288;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE  = 17'd65536;
    localparam logic [GAIN_W-1:0]   GAIN_MAX    = 20'd1048575;

    // Sine series: four nested terms, divisors 72, 42, 20, 6 from the
    // innermost out. Each division of a Q0.30 value is a multiply by
    // ceil(2^(30+l)/d) and a shift by 30+l, with l = ceil(log2(d)); this is
    // exact for every dividend below 2^30.
    localparam int SERIES_TERMS = 4;
    localparam int SERIES_W = 2;

    function automatic logic [31:0] series_recip(input logic [SERIES_W-1:0] j);
        logic [31:0] m;
        case (j)
            2'd0:    m = 32'd1908874354;
            2'd1:    m = 32'd1636178018;
            2'd2:    m = 32'd1717986919;
            default: m = 32'd1431655766;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] series_shift(input logic [SERIES_W-1:0] j);
        logic [5:0] s;
        case (j)
            2'd0:    s = 6'd37;
            2'd1:    s = 6'd36;
            2'd2:    s = 6'd35;
            default: s = 6'd33;
        endcase
        return s;
    endfunction

endpackage

FILE: design/split_cosine_edge_taper_unit.sv
// Split cosine edge taper unit: tapers the ends of a sample block with a
// cosine bell and reports an amplitude correction ratio with the last item.
// Depends on scet_pkg.
//
//  Channel  | Dir | Fields (low bit first)
//  ---------+-----+-----------------------------------------------------
//  s_       | in  | tdata: sample
//  m_       | out | tdata: tapered_sample, gain; tuser: gain_valid;
//           |     | tlast: last_sample
//  cfg_     | in  | wen, index (0 count, 1 start fraction, 2 end fraction)
//
// One item at a time through a shared 32x32 multiplier and a radix-2
// divider. Each item passes the position, apply, round and output steps;
// the first item of a block adds the ramp length steps, each ramp that
// covers the item adds a phase division and the sine series, and the last
// item of a block with a nonzero area adds the gain division.
// Reset is synchronous; a finished item waits in the output register while
// the next item is taken in, and the sequencer stalls only when a second
// result is ready before the first one has been taken.
module split_cosine_edge_taper_unit #(
    parameter int MAX_SAMPLES = scet_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = scet_pkg::DEF_SAMPLE_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // tapered_sample, gain
    output logic [((SAMPLE_BITS+scet_pkg::GAIN_W+7)/8)*8-1:0] m_tdata,
    // gain_valid
    output logic m_tuser,
    output logic m_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    input  logic cfg_wen,
    input  logic [scet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scet_pkg::CFG_W-1:0] cfg_wdata
);
    import scet_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES+1);
    localparam int SUM_W  = CNT_W + 18;
    localparam int DIV_W  = CNT_W + 33;
    localparam int DEN_W  = SUM_W;
    localparam int DCNT_W = $clog2(DIV_W+1);
    localparam int PD_IT  = CNT_W + PHASE_FRAC;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_LENF  = 5'd1;
    localparam logic [4:0] ST_LENB  = 5'd2;
    localparam logic [4:0] ST_LENE  = 5'd3;
    localparam logic [4:0] ST_POS   = 5'd4;
    localparam logic [4:0] ST_PDIV  = 5'd5;
    localparam logic [4:0] ST_PWAIT = 5'd6;
    localparam logic [4:0] ST_TMUL  = 5'd7;
    localparam logic [4:0] ST_T     = 5'd8;
    localparam logic [4:0] ST_T2    = 5'd9;
    localparam logic [4:0] ST_T2D   = 5'd10;
    localparam logic [4:0] ST_AMUL  = 5'd11;
    localparam logic [4:0] ST_RMUL  = 5'd12;
    localparam logic [4:0] ST_RQ    = 5'd13;
    localparam logic [4:0] ST_SMUL  = 5'd14;
    localparam logic [4:0] ST_S     = 5'd15;
    localparam logic [4:0] ST_FMUL  = 5'd16;
    localparam logic [4:0] ST_G     = 5'd17;
    localparam logic [4:0] ST_APPLY = 5'd18;
    localparam logic [4:0] ST_RND   = 5'd19;
    localparam logic [4:0] ST_GWAIT = 5'd20;
    localparam logic [4:0] ST_OUT   = 5'd21;

    // Configuration and block state
    logic [CFG_W-1:0] count_reg, start_frac_reg, end_frac_reg;
    logic [CNT_W-1:0] sample_index_reg, front_len_reg, back_len_reg;
    logic [SUM_W-1:0] area_reg;

    // Item work registers
    logic [4:0] state_reg, state_next;
    logic [SAMPLE_BITS-1:0] raw_reg;
    logic [CNT_W-1:0] i_reg, k_reg;
    logic last_reg, back_act_reg, ramp_sel_reg;
    logic [PHASE_W-1:0] p_reg;
    logic [Q30_W-1:0] t_reg, t2_reg, a_reg, s_reg;
    logic [SERIES_W-1:0] term_reg;
    logic [FACTOR_W-1:0] fac_reg;
    logic [63:0] prod_reg;
    logic [SAMPLE_BITS-1:0] tap_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Divider
    logic [DIV_W-1:0] div_num_reg;
    logic [DEN_W-1:0] div_rem_reg, div_den_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [DEN_W:0] rem_sh, rem_sub;
    logic div_ge, div_done;

    // Output register
    logic m_valid_reg, m_last_reg;
    logic [SAMPLE_BITS-1:0] m_tap_reg;
    logic [GAIN_W-1:0] m_gain_reg;

    // Combinational helpers
    logic [CNT_W-1:0] n_eff, i_now, pos_sel, len_sel;
    logic [CFG_W-1:0] fs_c, fe_c;
    logic [31:0] mul_a, mul_b;
    logic [PHASE_W-1:0] u_val;
    logic [Q30_W-1:0] f_val, g_val;
    logic [FACTOR_W-1:0] factor_val;
    logic [SAMPLE_BITS-1:0] mag, r_val;
    logic [63:0] rnd_sum, q_val;
    logic [PD_IT-1:0] p_num;
    logic [DIV_W-1:0] g_num;
    logic [CNT_W:0] units;
    logic accept, out_free, cfg_restart;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign cfg_restart = cfg_wen && (cfg_index == REG_SAMPLE_COUNT ||
                                     cfg_index == REG_START_FRACTION ||
                                     cfg_index == REG_END_FRACTION);

    // Effective count and clamped fractions
    always_comb begin
        if (count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(count_reg) > 32'(MAX_SAMPLES)) begin
            n_eff = CNT_W'(MAX_SAMPLES);
        end else begin
            n_eff = CNT_W'(count_reg);
        end
        fs_c = (start_frac_reg > FRACTION_ONE) ? FRACTION_ONE : start_frac_reg;
        fe_c = (end_frac_reg > FRACTION_ONE) ? FRACTION_ONE : end_frac_reg;
        i_now = (sample_index_reg >= n_eff) ? n_eff - CNT_W'(1) : sample_index_reg;
    end

    // Ramp operand selection and phase numerator
    assign pos_sel = ramp_sel_reg ? k_reg : i_reg;
    assign len_sel = ramp_sel_reg ? back_len_reg : front_len_reg;
    assign p_num   = {pos_sel, {PHASE_FRAC{1'b0}}} + PD_IT'(len_sel >> 1);
    assign u_val   = (p_reg <= PHASE_HALF) ? p_reg : PHASE_ONE - p_reg;
    assign units   = (CNT_W+1)'(front_len_reg) + (CNT_W+1)'(back_len_reg);
    assign g_num   = (DIV_W'(units) << 32) + DIV_W'(area_reg >> 1);

    // Series term quotient from the reciprocal product
    assign q_val   = prod_reg >> series_shift(term_reg);

    // Factor from the squared sine
    always_comb begin
        f_val = prod_reg[60:30];
        g_val = (p_reg <= PHASE_HALF) ? f_val : Q30_ONE - f_val;
        factor_val = FACTOR_W'((32'(g_val) + 32'd8192) >> 14);
    end

    // Sample magnitude and rounded product
    assign mag     = raw_reg[SAMPLE_BITS-1] ? (~raw_reg + SAMPLE_BITS'(1)) : raw_reg;
    assign rnd_sum = prod_reg + 64'd32768;
    assign r_val   = rnd_sum[SAMPLE_BITS+15:16];

    // Shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LENF: begin
                mul_a = 32'(fs_c);
                mul_b = 32'(n_eff);
            end
            ST_LENB: begin
                mul_a = 32'(fe_c);
                mul_b = 32'(n_eff);
            end
            ST_TMUL: begin
                mul_a = PI_HALF_Q30;
                mul_b = 32'(u_val);
            end
            ST_T2: begin
                mul_a = 32'(t_reg);
                mul_b = 32'(t_reg);
            end
            ST_AMUL: begin
                mul_a = 32'(t2_reg);
                mul_b = 32'(a_reg);
            end
            ST_RMUL: begin
                mul_a = 32'(prod_reg[59:30]);
                mul_b = series_recip(term_reg);
            end
            ST_SMUL: begin
                mul_a = 32'(t_reg);
                mul_b = 32'(a_reg);
            end
            ST_FMUL: begin
                mul_a = 32'(s_reg);
                mul_b = 32'(s_reg);
            end
            ST_APPLY: begin
                mul_a = 32'(mag);
                mul_b = 32'(fac_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider step
    assign rem_sh   = {div_rem_reg, div_num_reg[DIV_W-1]};
    assign div_ge   = rem_sh >= {1'b0, div_den_reg};
    assign rem_sub  = rem_sh - {1'b0, div_den_reg};
    assign div_done = (div_cnt_reg == '0);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) begin
                state_next = (sample_index_reg == '0) ? ST_LENF : ST_POS;
            end
            ST_LENF:  state_next = ST_LENB;
            ST_LENB:  state_next = ST_LENE;
            ST_LENE:  state_next = ST_POS;
            ST_POS: begin
                if ((i_now < front_len_reg) ||
                    ((n_eff - CNT_W'(1) - i_now) < back_len_reg)) begin
                    state_next = ST_PDIV;
                end else begin
                    state_next = ST_APPLY;
                end
            end
            ST_PDIV:  state_next = ST_PWAIT;
            ST_PWAIT: if (div_done) begin
                state_next = ST_TMUL;
            end
            ST_TMUL:  state_next = ST_T;
            ST_T:     state_next = ST_T2;
            ST_T2:    state_next = ST_T2D;
            ST_T2D:   state_next = ST_AMUL;
            ST_AMUL:  state_next = ST_RMUL;
            ST_RMUL:  state_next = ST_RQ;
            ST_RQ: begin
                state_next = (term_reg == SERIES_W'(SERIES_TERMS-1)) ? ST_SMUL : ST_AMUL;
            end
            ST_SMUL:  state_next = ST_S;
            ST_S:     state_next = ST_FMUL;
            ST_FMUL:  state_next = ST_G;
            ST_G: begin
                state_next = (!ramp_sel_reg && back_act_reg) ? ST_PDIV : ST_APPLY;
            end
            ST_APPLY: state_next = ST_RND;
            ST_RND: begin
                state_next = (last_reg && area_reg != '0) ? ST_GWAIT : ST_OUT;
            end
            ST_GWAIT: if (div_done) begin
                state_next = ST_OUT;
            end
            ST_OUT: if (out_free) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            count_reg        <= RST_SAMPLE_COUNT;
            start_frac_reg   <= RST_FRACTION;
            end_frac_reg     <= RST_FRACTION;
            sample_index_reg <= '0;
            front_len_reg    <= '0;
            back_len_reg     <= '0;
            area_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            // output register valid
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LENB: front_len_reg <= CNT_W'((prod_reg + 64'd32768) >> 16);
                ST_LENE: back_len_reg  <= CNT_W'((prod_reg + 64'd32768) >> 16);
                default: ;
            endcase
            if (cfg_wen) begin
                unique case (cfg_index)
                    REG_SAMPLE_COUNT:   count_reg      <= cfg_wdata;
                    REG_START_FRACTION: start_frac_reg <= cfg_wdata;
                    REG_END_FRACTION:   end_frac_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            // block position and area; register writes restart the block
            if (cfg_restart) begin
                sample_index_reg <= '0;
                area_reg         <= '0;
            end else if (state_reg == ST_G) begin
                area_reg <= area_reg + SUM_W'(factor_val);
            end else if (state_reg == ST_OUT && out_free) begin
                if (last_reg) begin
                    sample_index_reg <= '0;
                    area_reg         <= '0;
                end else begin
                    sample_index_reg <= i_reg + CNT_W'(1);
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: if (accept) begin
                    raw_reg <= s_tdata[SAMPLE_BITS-1:0];
                end
                ST_POS: begin
                    i_reg         <= i_now;
                    k_reg         <= n_eff - CNT_W'(1) - i_now;
                    last_reg      <= (i_now == n_eff - CNT_W'(1));
                    back_act_reg  <= (n_eff - CNT_W'(1) - i_now) < back_len_reg;
                    ramp_sel_reg  <= !(i_now < front_len_reg);
                    fac_reg       <= FACTOR_ONE;
                end
                ST_PDIV: begin
                    div_num_reg <= DIV_W'(p_num) << (DIV_W - PD_IT);
                    div_den_reg <= DEN_W'(len_sel);
                    div_rem_reg <= '0;
                    div_cnt_reg <= DCNT_W'(PD_IT);
                end
                ST_PWAIT: begin
                    if (div_done) begin
                        p_reg <= div_num_reg[PHASE_W-1:0];
                    end else begin
                        div_rem_reg <= div_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                        div_num_reg <= {div_num_reg[DIV_W-2:0], div_ge};
                        div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                    end
                end
                ST_T:   t_reg <= prod_reg[50:20];
                ST_T2D: begin
                    t2_reg   <= prod_reg[60:30];
                    a_reg    <= Q30_ONE;
                    term_reg <= '0;
                end
                ST_RQ: begin
                    a_reg    <= Q30_ONE - Q30_W'(q_val);
                    term_reg <= term_reg + SERIES_W'(1);
                end
                ST_S: s_reg <= prod_reg[60:30];
                ST_G: begin
                    fac_reg <= factor_val;
                    if (!ramp_sel_reg && back_act_reg) begin
                        ramp_sel_reg <= 1'b1;
                    end
                end
                ST_RND: begin
                    tap_reg  <= raw_reg[SAMPLE_BITS-1] ? (~r_val + SAMPLE_BITS'(1)) : r_val;
                    gain_reg <= last_reg ? FACTOR_ONE[GAIN_W-1:0] : '0;
                    if (last_reg && area_reg != '0) begin
                        div_num_reg <= g_num;
                        div_den_reg <= area_reg;
                        div_rem_reg <= '0;
                        div_cnt_reg <= DCNT_W'(DIV_W);
                    end
                end
                ST_GWAIT: begin
                    if (div_done) begin
                        gain_reg <= (div_num_reg > DIV_W'(GAIN_MAX)) ? GAIN_MAX
                                                                     : div_num_reg[GAIN_W-1:0];
                    end else begin
                        div_rem_reg <= div_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                        div_num_reg <= {div_num_reg[DIV_W-2:0], div_ge};
                        div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                    end
                end
                ST_OUT: if (out_free) begin
                    m_tap_reg  <= tap_reg;
                    m_gain_reg <= gain_reg;
                    m_last_reg <= last_reg;
                end
                default: ;
            endcase
        end
    end

    // Output packing
    always_comb begin
        m_tdata = '0;
        m_tdata[SAMPLE_BITS-1:0] = m_tap_reg;
        m_tdata[SAMPLE_BITS+GAIN_W-1:SAMPLE_BITS] = m_gain_reg;
    end
    assign m_tuser  = m_last_reg;
    assign m_tlast  = m_last_reg;
    assign m_tvalid = m_valid_reg;

endmodule
